// File: sv/ssl_pkg.sv
// shared types and codes for the shifting slot list
// used by ssl_cell, ssl_read_tree and shifting_slot_list; no dependencies
package ssl_pkg;

  localparam int unsigned IdxW   = 6;
  localparam int unsigned OutCntW = 7;

  typedef enum logic [1:0] {
    MODE_APPEND  = 2'd0,
    MODE_PREPEND = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] name_ref;
    logic [7:0]  age;
    logic [31:0] address_ref;
  } entry_t;

  // per-transaction command broadcast to every cell
  typedef struct packed {
    logic append;
    logic prepend;
    logic remove;
    logic read;
  } cell_ctl_t;

endpackage

// File: sv/ssl_cell.sv
// one slot of the list: holds an entry, shifts to and from its neighbors
// depends on ssl_pkg
module ssl_cell #(
  parameter int unsigned POS   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                  clk_i,
  input  ssl_pkg::cell_ctl_t    ctl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [ssl_pkg::IdxW-1:0] idx_i,
  input  ssl_pkg::entry_t       new_i,
  input  ssl_pkg::entry_t       left_i,
  input  ssl_pkg::entry_t       right_i,
  output ssl_pkg::entry_t       ent_o,
  output ssl_pkg::entry_t       rd_o
);
  import ssl_pkg::*;

  localparam int unsigned CmpW = (CNT_W > IdxW) ? CNT_W : IdxW;
  localparam logic [CmpW-1:0] PosC = CmpW'(POS);

  entry_t ent_q, ent_d;
  logic   at_tail, at_or_above_idx, hit;

  assign at_tail         = (count_i == CNT_W'(POS));
  assign at_or_above_idx = (PosC >= CmpW'(idx_i));
  assign hit             = ctl_i.read && (PosC == CmpW'(idx_i));

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.append && at_tail) begin
      ent_d = new_i;
    end else if (ctl_i.prepend) begin
      ent_d = (POS == 0) ? new_i : left_i;
    end else if (ctl_i.remove && at_or_above_idx) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
  assign rd_o  = hit ? ent_q : '0;

endmodule

// File: sv/ssl_read_tree.sv
// registered or-tree collecting the one-hot read contribution of the cells
// depends on ssl_pkg
module ssl_read_tree #(
  parameter int unsigned N = 64
) (
  input  logic            clk_i,
  input  logic            ld_i,
  input  ssl_pkg::entry_t rd_i [N],
  output ssl_pkg::entry_t rd_data_o
);
  import ssl_pkg::*;

  localparam int unsigned GrpSize = 8;
  localparam int unsigned NumGrp  = (N + GrpSize - 1) / GrpSize;

  entry_t grp_q [NumGrp];
  entry_t grp_d [NumGrp];

  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GrpSize; k++) begin
        if (g * GrpSize + k < N) begin
          grp_d[g] = grp_d[g] | rd_i[g * GrpSize + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    rd_data_o = '0;
    for (int g = 0; g < NumGrp; g++) begin
      rd_data_o = rd_data_o | grp_q[g];
    end
  end

endmodule

// File: sv/shifting_slot_list.sv
// shifting slot list: dense ordered list of CAPACITY entries in a row of cells
// the result is registered in the read or-tree groups, then in the result registers
// a new transaction waits while the previous one is in the registered read or-tree
// every insert, remove or shift completes in the accept cycle across all cells at once
// reset: entry count and handshake state clear, slot contents stay undefined
// depends on ssl_pkg, ssl_cell, ssl_read_tree
module shifting_slot_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [ssl_pkg::IdxW-1:0]    slot_index_i,
  input  logic [31:0]                 name_ref_i,
  input  logic [7:0]                  age_i,
  input  logic [31:0]                 address_ref_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [ssl_pkg::OutCntW-1:0] entry_count_o,
  output logic [31:0]                 read_name_ref_o,
  output logic [7:0]                  read_age_o,
  output logic [31:0]                 read_address_ref_o
);
  import ssl_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > IdxW) ? CntW : IdxW;

  // handshake and control state
  logic             in_acc, out_acc;
  logic             st1_q, st1_d;
  logic             out_valid_q, out_valid_d;
  logic [CntW-1:0]  count_q, count_d;
  status_e          pend_status_q, pend_status_d;

  // result payload registers
  status_e              out_status_q;
  logic [OutCntW-1:0]   out_count_q;
  entry_t               out_rd_q;

  // command decode
  logic      is_full, idx_bad;
  cell_ctl_t ctl;
  entry_t    new_ent;
  entry_t    rd_data;

  // cell row wiring
  entry_t cell_ent [CAPACITY];
  entry_t cell_rd  [CAPACITY];

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // a new transaction needs an idle tree stage and the last result gone or leaving
  assign in_ready_o = !st1_q && (!out_valid_q || out_ready_i);

  assign is_full = (count_q == CntW'(CAPACITY));
  assign idx_bad = (CmpW'(slot_index_i) >= CmpW'(count_q));

  assign new_ent.name_ref    = name_ref_i;
  assign new_ent.age         = age_i;
  assign new_ent.address_ref = address_ref_i;

  always_comb begin
    ctl           = '0;
    count_d       = count_q;
    pend_status_d = pend_status_q;
    if (in_acc) begin
      pend_status_d = STAT_OK;
      unique case (mode_e'(mode_i))
        MODE_APPEND: begin
          if (is_full) begin
            pend_status_d = STAT_FULL;
          end else begin
            ctl.append = 1'b1;
            count_d    = count_q + CntW'(1);
          end
        end
        MODE_PREPEND: begin
          if (is_full) begin
            pend_status_d = STAT_FULL;
          end else begin
            ctl.prepend = 1'b1;
            count_d     = count_q + CntW'(1);
          end
        end
        MODE_REMOVE: begin
          if (idx_bad) begin
            pend_status_d = STAT_RANGE;
          end else begin
            ctl.remove = 1'b1;
            count_d    = count_q - CntW'(1);
          end
        end
        MODE_READ: begin
          if (idx_bad) begin
            pend_status_d = STAT_RANGE;
          end else begin
            ctl.read = 1'b1;
          end
        end
        default: begin
          pend_status_d = STAT_OK;
        end
      endcase
    end
  end

  // row of cells: each takes from its left neighbor on prepend and from
  // its right neighbor on remove; the last cell feeds back on itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent, right_ent;

    if (i == 0) begin : g_first
      assign left_ent = new_ent;
    end else begin : g_mid
      assign left_ent = cell_ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = cell_ent[i];
    end else begin : g_inner
      assign right_ent = cell_ent[i+1];
    end

    ssl_cell #(
      .POS   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .count_i (count_q),
      .idx_i   (slot_index_i),
      .new_i   (new_ent),
      .left_i  (left_ent),
      .right_i (right_ent),
      .ent_o   (cell_ent[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // read path: only the addressed cell drives nonzero data
  ssl_read_tree #(
    .N (CAPACITY)
  ) u_read_tree (
    .clk_i     (clk_i),
    .ld_i      (in_acc),
    .rd_i      (cell_rd),
    .rd_data_o (rd_data)
  );

  assign st1_d = in_acc;

  always_comb begin
    out_valid_d = out_valid_q;
    if (st1_q) begin
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      count_q       <= '0;
      pend_status_q <= STAT_OK;
    end else begin
      st1_q         <= st1_d;
      out_valid_q   <= out_valid_d;
      count_q       <= count_d;
      pend_status_q <= pend_status_d;
    end
  end

  // result payload, loaded when the or-tree output settles
  always_ff @(posedge clk_i) begin
    if (st1_q) begin
      out_status_q <= pend_status_q;
      out_count_q  <= OutCntW'(count_q);
      out_rd_q     <= rd_data;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign entry_count_o      = out_count_q;
  assign read_name_ref_o    = out_rd_q.name_ref;
  assign read_age_o         = out_rd_q.age;
  assign read_address_ref_o = out_rd_q.address_ref;

  // count never leaves its legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // the tree stage never overlaps a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st1_q |-> !out_valid_q)
    else $error("result overwritten before it was taken");

  // a rejected insert leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_full && (mode_i == MODE_APPEND || mode_i == MODE_PREPEND))
      |=> $stable(count_q))
    else $error("count changed on full insert");

  // read fields stay zero on a failed transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != STAT_OK) |-> (out_rd_q == '0))
    else $error("read data on failed transaction");

endmodule
